/* sv/tdf_pkg.sv */
package tdf_pkg;

	localparam int VALUE_W = 31;
	localparam int EXP_W = 5;
	localparam int KIND_W = 2;

	localparam int PRIME_LIMIT = 20;
	localparam int PRIME_W = $clog2(PRIME_LIMIT + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int DIV_STEP = 8;
	localparam int DIV_CYCLES = (VALUE_W + DIV_STEP - 1) / DIV_STEP;
	localparam int DIV_PAD_W = DIV_CYCLES * DIV_STEP;
	localparam int DIV_CNT_W = $clog2(DIV_CYCLES + 1);

	typedef enum logic [KIND_W-1:0] {
		KIND_PRIME    = 2'd0,
		KIND_COFACTOR = 2'd1,
		KIND_NOTHING  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_COF
	} back_state_t;

	function automatic int count_primes();
		bit comp [PRIME_LIMIT+1];
		int n;
		n = 0;
		for (int i = 0; i <= PRIME_LIMIT; i++)
			comp[i] = 1'b0;
		for (int i = 2; i <= PRIME_LIMIT; i++) begin
			if (!comp[i]) begin
				n++;
				for (int j = i + i; j <= PRIME_LIMIT; j += i)
					comp[j] = 1'b1;
			end
		end
		return n;
	endfunction

	localparam int PRIME_COUNT = count_primes();
	localparam int IDX_W = (PRIME_COUNT > 1) ? $clog2(PRIME_COUNT) : 1;

	typedef logic [PRIME_W-1:0] prime_tab_t [PRIME_COUNT];

	function automatic prime_tab_t build_primes();
		prime_tab_t t;
		bit comp [PRIME_LIMIT+1];
		int n;
		n = 0;
		for (int i = 0; i < PRIME_COUNT; i++)
			t[i] = '0;
		for (int i = 0; i <= PRIME_LIMIT; i++)
			comp[i] = 1'b0;
		for (int i = 2; i <= PRIME_LIMIT; i++) begin
			if (!comp[i]) begin
				t[n] = PRIME_W'(i);
				n++;
				for (int j = i + i; j <= PRIME_LIMIT; j += i)
					comp[j] = 1'b1;
			end
		end
		return t;
	endfunction

	localparam prime_tab_t PRIMES = build_primes();

	typedef struct packed {
		logic               nothing;
		logic [VALUE_W-1:0] value;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} queue_out_t;

	typedef struct packed {
		logic               start;
		logic [VALUE_W-1:0] dividend;
		logic [PRIME_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic               zero_rem;
		logic [VALUE_W-1:0] quotient;
	} div_rsp_t;

endpackage

/* sv/trial_division_factorizer.sv */
// Trial-division prime factorizer.
// Input: pulse start with value; the beat is taken when start is high and
// busy is low. A two-entry queue sits between the front and the factoring
// engine, so up to two values are taken while an earlier one is still in work.
// Output: each result is shown for one cycle with valid high; factor and
// exponent in ascending prime order, kind 0 for a prime, 1 for a leftover
// cofactor above the table, 2 for an input of 0 or 1; last marks the final
// result of a value. The receiver cannot stall: results simply appear.
// An input of 0 or 1 is written into the queue, taken by an idle engine and its
// result registered at the output. Every trial division goes through one shared
// divider that retires 8 quotient bits per cycle; a value needs one trial per
// successful division plus one failing trial per table prime passed over, at
// most 34, and a leftover cofactor goes through the cofactor state first.
// Reset empties the queue and the engine; no results appear until new beats.
module trial_division_factorizer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [tdf_pkg::VALUE_W-1:0]  value,
	output logic                         valid,
	output logic [tdf_pkg::VALUE_W-1:0]  factor,
	output logic [tdf_pkg::EXP_W-1:0]    exponent,
	output logic [tdf_pkg::KIND_W-1:0]   kind,
	output logic                         last
);

	logic                full;
	logic                push;
	logic                pop;
	tdf_pkg::job_t       job;
	tdf_pkg::queue_out_t head;
	tdf_pkg::div_req_t   req;
	tdf_pkg::div_rsp_t   rsp;

	tdf_front u_front (
		.start (start),
		.value (value),
		.full  (full),
		.busy  (busy),
		.push  (push),
		.job   (job)
	);

	tdf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (job),
		.full     (full),
		.pop      (pop),
		.head     (head)
	);

	tdf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	tdf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.req      (req),
		.rsp      (rsp),
		.valid    (valid),
		.factor   (factor),
		.exponent (exponent),
		.kind     (kind),
		.last     (last)
	);

endmodule

/* sv/tdf_front.sv */
module tdf_front (
	input  logic                         start,
	input  logic [tdf_pkg::VALUE_W-1:0]  value,
	input  logic                         full,
	output logic                         busy,
	output logic                         push,
	output tdf_pkg::job_t                job
);

	assign busy = full;
	assign push = start & ~full;

	always_comb begin
		job.value = value;
		job.nothing = (value <= tdf_pkg::VALUE_W'(1));
	end

endmodule

/* sv/tdf_queue.sv */
module tdf_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tdf_pkg::job_t        push_job,
	output logic                 full,
	input  logic                 pop,
	output tdf_pkg::queue_out_t  head
);

	tdf_pkg::job_t mem_q [tdf_pkg::QUEUE_DEPTH];
	logic [tdf_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [tdf_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [tdf_pkg::QCNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == tdf_pkg::QCNT_W'(tdf_pkg::QUEUE_DEPTH));
	assign do_push = push & ~full;
	assign do_pop = pop & head.valid;

	always_comb begin
		head.valid = (count_q != '0);
		head.job = mem_q[rd_ptr_q];
	end

	function automatic logic [tdf_pkg::QPTR_W-1:0] next_ptr(
		input logic [tdf_pkg::QPTR_W-1:0] p
	);
		if (p == tdf_pkg::QPTR_W'(tdf_pkg::QUEUE_DEPTH - 1))
			return '0;
		return p + tdf_pkg::QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + tdf_pkg::QCNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - tdf_pkg::QCNT_W'(1);
		end
	end

endmodule

/* sv/tdf_div.sv */
module tdf_div (
	input  logic                clk,
	input  logic                arst_n,
	input  tdf_pkg::div_req_t   req,
	output tdf_pkg::div_rsp_t   rsp
);

	logic [tdf_pkg::DIV_PAD_W-1:0] work_q;
	logic [tdf_pkg::PRIME_W-1:0]   rem_q;
	logic [tdf_pkg::PRIME_W-1:0]   dvs_q;
	logic [tdf_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          done_q;
	logic [tdf_pkg::DIV_PAD_W-1:0] work_d;
	logic [tdf_pkg::PRIME_W-1:0]   rem_d;
	logic [tdf_pkg::PRIME_W:0]     trial;

	always_comb begin
		rem_d = rem_q;
		work_d = work_q;
		trial = '0;
		for (int k = 0; k < tdf_pkg::DIV_STEP; k++) begin
			trial = {rem_d, work_d[tdf_pkg::DIV_PAD_W-1]};
			work_d = {work_d[tdf_pkg::DIV_PAD_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				trial = trial - {1'b0, dvs_q};
				work_d[0] = 1'b1;
			end
			rem_d = trial[tdf_pkg::PRIME_W-1:0];
		end
	end

	always_comb begin
		rsp.done = done_q;
		rsp.zero_rem = (rem_q == '0);
		rsp.quotient = work_q[tdf_pkg::VALUE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= tdf_pkg::DIV_PAD_W'(req.dividend);
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			work_q <= work_d;
			rem_q <= rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == tdf_pkg::DIV_CNT_W'(1)) && !req.start;
			if (req.start)
				cnt_q <= tdf_pkg::DIV_CNT_W'(tdf_pkg::DIV_CYCLES);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - tdf_pkg::DIV_CNT_W'(1);
		end
	end

endmodule

/* sv/tdf_back.sv */
module tdf_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tdf_pkg::queue_out_t          head,
	output logic                         pop,
	output tdf_pkg::div_req_t            req,
	input  tdf_pkg::div_rsp_t            rsp,
	output logic                         valid,
	output logic [tdf_pkg::VALUE_W-1:0]  factor,
	output logic [tdf_pkg::EXP_W-1:0]    exponent,
	output logic [tdf_pkg::KIND_W-1:0]   kind,
	output logic                         last
);

	localparam logic [tdf_pkg::IDX_W-1:0] LAST_IDX = tdf_pkg::IDX_W'(tdf_pkg::PRIME_COUNT - 1);

	tdf_pkg::back_state_t state_q, state_d;
	logic [tdf_pkg::VALUE_W-1:0] x_q, x_d;
	logic [tdf_pkg::IDX_W-1:0]   idx_q, idx_d;
	logic [tdf_pkg::EXP_W-1:0]   exp_q, exp_d;
	logic [tdf_pkg::IDX_W-1:0]   div_idx;

	logic                        valid_q;
	logic [tdf_pkg::VALUE_W-1:0] factor_q;
	logic [tdf_pkg::EXP_W-1:0]   exponent_q;
	tdf_pkg::kind_t              kind_q;
	logic                        last_q;

	logic                        emit;
	logic [tdf_pkg::VALUE_W-1:0] e_factor;
	logic [tdf_pkg::EXP_W-1:0]   e_exp;
	tdf_pkg::kind_t              e_kind;
	logic                        e_last;
	logic [tdf_pkg::VALUE_W-1:0] cur_prime;

	assign cur_prime = tdf_pkg::VALUE_W'(tdf_pkg::PRIMES[idx_q]);

	always_comb begin
		state_d = state_q;
		x_d = x_q;
		idx_d = idx_q;
		exp_d = exp_q;
		pop = 1'b0;
		req.start = 1'b0;
		req.dividend = x_q;
		div_idx = idx_q;
		emit = 1'b0;
		e_factor = '0;
		e_exp = '0;
		e_kind = tdf_pkg::KIND_PRIME;
		e_last = 1'b0;
		unique case (state_q)
			tdf_pkg::BK_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					if (head.job.nothing) begin
						emit = 1'b1;
						e_kind = tdf_pkg::KIND_NOTHING;
						e_last = 1'b1;
					end else begin
						x_d = head.job.value;
						idx_d = '0;
						exp_d = '0;
						req.start = 1'b1;
						req.dividend = head.job.value;
						div_idx = '0;
						state_d = tdf_pkg::BK_DIV;
					end
				end
			end
			tdf_pkg::BK_DIV: begin
				if (rsp.done) begin
					if (rsp.zero_rem) begin
						exp_d = exp_q + tdf_pkg::EXP_W'(1);
						x_d = rsp.quotient;
						if (rsp.quotient == tdf_pkg::VALUE_W'(1)) begin
							emit = 1'b1;
							e_factor = cur_prime;
							e_exp = exp_q + tdf_pkg::EXP_W'(1);
							e_last = 1'b1;
							state_d = tdf_pkg::BK_IDLE;
						end else begin
							req.start = 1'b1;
							req.dividend = rsp.quotient;
						end
					end else begin
						if (exp_q != '0) begin
							emit = 1'b1;
							e_factor = cur_prime;
							e_exp = exp_q;
						end
						exp_d = '0;
						if (idx_q == LAST_IDX) begin
							state_d = tdf_pkg::BK_COF;
						end else begin
							idx_d = idx_q + tdf_pkg::IDX_W'(1);
							div_idx = idx_q + tdf_pkg::IDX_W'(1);
							req.start = 1'b1;
						end
					end
				end
			end
			tdf_pkg::BK_COF: begin
				emit = 1'b1;
				e_factor = x_q;
				e_exp = tdf_pkg::EXP_W'(1);
				e_kind = tdf_pkg::KIND_COFACTOR;
				e_last = 1'b1;
				state_d = tdf_pkg::BK_IDLE;
			end
			default: state_d = tdf_pkg::BK_IDLE;
		endcase
		req.divisor = tdf_pkg::PRIMES[div_idx];
	end

	always_ff @(posedge clk) begin
		x_q <= x_d;
		idx_q <= idx_d;
		exp_q <= exp_d;
		if (emit) begin
			factor_q <= e_factor;
			exponent_q <= e_exp;
			kind_q <= e_kind;
			last_q <= e_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdf_pkg::BK_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= emit;
		end
	end

	assign valid = valid_q;
	assign factor = factor_q;
	assign exponent = exponent_q;
	assign kind = kind_q;
	assign last = last_q;

endmodule

/* sv/tdf_checker.sv */
module tdf_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         valid,
	input logic [tdf_pkg::VALUE_W-1:0]  factor,
	input logic [tdf_pkg::EXP_W-1:0]    exponent,
	input logic [tdf_pkg::KIND_W-1:0]   kind,
	input logic                         last
);

	a_nothing_shape: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind == tdf_pkg::KIND_NOTHING |-> last && factor == '0 && exponent == '0)
		else $error("nothing result malformed");

	a_cofactor_shape: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind == tdf_pkg::KIND_COFACTOR |->
			last && exponent == tdf_pkg::EXP_W'(1) && factor > tdf_pkg::VALUE_W'(1))
		else $error("cofactor result malformed");

	a_prime_shape: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind == tdf_pkg::KIND_PRIME |->
			exponent != '0 && factor >= tdf_pkg::VALUE_W'(2)
			&& factor <= tdf_pkg::VALUE_W'(tdf_pkg::PRIME_LIMIT))
		else $error("prime result malformed");

	a_no_interleave: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |=> !(valid && kind == tdf_pkg::KIND_NOTHING))
		else $error("new value result inside unfinished run");

endmodule

bind trial_division_factorizer tdf_checker u_tdf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.valid    (valid),
	.factor   (factor),
	.exponent (exponent),
	.kind     (kind),
	.last     (last)
);
